// ----- rtl/sdg_pkg.sv -----
// Shared types, constants and helper functions for the stratified dice generator.
// No dependencies; every other file of the block but sdg_modu refers to this package by scoped names.
package sdg_pkg;

    // Defaults for the top-level parameters
    localparam int TURNS_DEF  = 128;
    localparam int LEVELS_DEF = 6;

    // Fixed sizes
    localparam int FACES     = 36;
    localparam int MT_N      = 624;
    localparam int MT_M      = 397;
    localparam int SEED_W    = 32;
    localparam int TRIAL_W   = 24;
    localparam int TURN_IN_W = 7;
    localparam int DIE_W     = 3;
    localparam int FACE_W    = 6;
    localparam int IDX_W     = 10;   // twister address and position
    localparam int TURN_W    = 10;   // holds any turn up to the largest table
    localparam int LVL_W     = 3;    // holds any level up to the deepest table

    // Twister constants
    localparam logic [31:0] MT_MULT   = 32'd1812433253;
    localparam logic [31:0] MT_MATRIX = 32'h9908B0DF;

    // Reciprocal of nine, scaled by 2^25, for the base-36 digit split
    localparam logic [21:0] RECIP9   = 22'd3728270;
    localparam int          RECIP_SH = 25;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SEED0,
        ST_SEED_MUL,
        ST_SEED_WR,
        ST_ROW,
        ST_NEXT,
        ST_TW_INIT,
        ST_TW_HI,
        ST_TW_RD,
        ST_TW_WR,
        ST_TEMPER,
        ST_DIV,
        ST_SW_RD,
        ST_SW_WR,
        ST_LAST_RD,
        ST_LAST_WR,
        ST_LK_MUL,
        ST_LK_RD,
        ST_LK_V,
        ST_DONE
    } state_t;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SEED0,
        OP_SEED_MUL,
        OP_SEED_WR,
        OP_ROW,
        OP_MT_RD,
        OP_TW_RD0,
        OP_TW_HI,
        OP_TW_RD,
        OP_TW_WR,
        OP_DIV_START,
        OP_SW_RD,
        OP_SW_WR,
        OP_LAST_RD,
        OP_LAST_WR,
        OP_LAST_BUILT,
        OP_LK_MUL,
        OP_LK_RD,
        OP_LK_V,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [IDX_W-1:0]   idx;
        logic [FACE_W-1:0]  k;
        logic [LVL_W-1:0]   lvl;
        logic [TURN_W-1:0]  turn;
    } sdg_cmd_t;

    typedef struct packed {
        logic need_rebuild;
        logic div_done;
        logic lk_last;
        logic out_free;
    } sdg_sts_t;

    // Twister output tempering
    function automatic logic [31:0] temper(input logic [31:0] y_in);
        logic [31:0] y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9D2C5680);
        y = y ^ ((y << 15) & 32'hEFC60000);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Face value divided by six
    function automatic logic [2:0] div6(input logic [FACE_W-1:0] v);
        logic [2:0] q;
        if (v >= 6'd30)      q = 3'd5;
        else if (v >= 6'd24) q = 3'd4;
        else if (v >= 6'd18) q = 3'd3;
        else if (v >= 6'd12) q = 3'd2;
        else if (v >= 6'd6)  q = 3'd1;
        else                 q = 3'd0;
        return q;
    endfunction

    function automatic logic [DIE_W-1:0] die_hi(input logic [FACE_W-1:0] v);
        return div6(v) + 3'd1;
    endfunction

    function automatic logic [DIE_W-1:0] die_lo(input logic [FACE_W-1:0] v);
        logic [FACE_W-1:0] r;
        r = v - 6'(div6(v)) * 6'd6;
        return r[2:0] + 3'd1;
    endfunction

endpackage

// ----- rtl/sdg_if.sv -----
// Channel interfaces: request word, result word and seed write word.
// Depends on sdg_pkg for the field widths.
interface sdg_req_if;
    logic                            valid;
    logic                            ready;
    logic [sdg_pkg::TRIAL_W-1:0]     trial_index;
    logic [sdg_pkg::TURN_IN_W-1:0]   turn_index;
    modport source (output valid, output trial_index, output turn_index, input ready);
    modport sink   (input valid, input trial_index, input turn_index, output ready);
endinterface

interface sdg_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [sdg_pkg::DIE_W-1:0]   die_first;
    logic [sdg_pkg::DIE_W-1:0]   die_second;
    modport source (output valid, output die_first, output die_second, input ready);
    modport sink   (input valid, input die_first, input die_second, output ready);
endinterface

interface sdg_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sdg_pkg::SEED_W-1:0]  seed;
    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface

// ----- rtl/sdg_modu.sv -----
// Remainder unit: 32-bit value modulo a 6-bit divisor, four bits a cycle.
// Depends on nothing outside this file.
module sdg_modu (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [5:0]  divisor,
    output logic [5:0]  rem,
    output logic        done
);

    logic [31:0] dvd_reg, dvd_next;
    logic [5:0]  dsr_reg;
    logic [5:0]  rem_reg, rem_next;
    logic [2:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    // Four restoring steps per cycle
    always_comb
    begin
        logic [6:0] r7;
        logic [5:0] r;
        r = rem_reg;
        for (int s = 0; s < 4; s++)
        begin
            r7 = {r, dvd_reg[31 - s]};
            if (r7 >= {1'b0, dsr_reg})
                r7 = r7 - {1'b0, dsr_reg};
            r = r7[5:0];
        end
        rem_next = r;
        dvd_next = dvd_reg << 4;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

// ----- rtl/sdg_ctrl.sv -----
// Controller: sequences table rebuild (seed, twist, shuffle) and the per-word lookup.
// Depends on sdg_pkg for state, command and status types.
module sdg_ctrl #(
    parameter int TURNS  = sdg_pkg::TURNS_DEF,
    parameter int LEVELS = sdg_pkg::LEVELS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sdg_pkg::sdg_sts_t sts,
    output sdg_pkg::sdg_cmd_t cmd
);

    sdg_pkg::state_t                   state_reg, state_next;
    logic [sdg_pkg::IDX_W-1:0]         i_reg, i_next;
    logic [sdg_pkg::IDX_W-1:0]         pos_reg, pos_next;
    logic [sdg_pkg::FACE_W-1:0]        k_reg, k_next;
    logic [sdg_pkg::LVL_W-1:0]         lvl_reg, lvl_next;
    logic [sdg_pkg::TURN_W-1:0]        turn_reg, turn_next;

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdg_pkg::ST_IDLE;
            i_reg     <= '0;
            pos_reg   <= '0;
            k_reg     <= '0;
            lvl_reg   <= '0;
            turn_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            pos_reg   <= pos_next;
            k_reg     <= k_next;
            lvl_reg   <= lvl_next;
            turn_reg  <= turn_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        lvl_next   = lvl_reg;
        turn_next  = turn_reg;
        req_ready  = 1'b0;
        cmd.op     = sdg_pkg::OP_NONE;
        cmd.idx    = i_reg;
        cmd.k      = k_reg;
        cmd.lvl    = lvl_reg;
        cmd.turn   = turn_reg;

        case (state_reg)
            sdg_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op   = sdg_pkg::OP_LOAD;
                    lvl_next = '0;
                    state_next = sts.need_rebuild ? sdg_pkg::ST_SEED0 : sdg_pkg::ST_LK_MUL;
                end
            end
            sdg_pkg::ST_SEED0:
            begin
                cmd.op     = sdg_pkg::OP_SEED0;
                i_next     = sdg_pkg::IDX_W'(1);
                state_next = sdg_pkg::ST_SEED_MUL;
            end
            sdg_pkg::ST_SEED_MUL:
            begin
                cmd.op     = sdg_pkg::OP_SEED_MUL;
                state_next = sdg_pkg::ST_SEED_WR;
            end
            sdg_pkg::ST_SEED_WR:
            begin
                cmd.op = sdg_pkg::OP_SEED_WR;
                if (i_reg == sdg_pkg::IDX_W'(sdg_pkg::MT_N - 1))
                begin
                    pos_next   = sdg_pkg::IDX_W'(sdg_pkg::MT_N);
                    lvl_next   = '0;
                    turn_next  = '0;
                    state_next = sdg_pkg::ST_ROW;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = sdg_pkg::ST_SEED_MUL;
                end
            end
            sdg_pkg::ST_ROW:
            begin
                cmd.op     = sdg_pkg::OP_ROW;
                k_next     = '0;
                state_next = sdg_pkg::ST_NEXT;
            end
            sdg_pkg::ST_NEXT:
            begin
                if (pos_reg == sdg_pkg::IDX_W'(sdg_pkg::MT_N))
                begin
                    i_next     = '0;
                    state_next = sdg_pkg::ST_TW_INIT;
                end
                else
                begin
                    cmd.op     = sdg_pkg::OP_MT_RD;
                    cmd.idx    = pos_reg;
                    pos_next   = pos_reg + 1'b1;
                    state_next = sdg_pkg::ST_TEMPER;
                end
            end
            sdg_pkg::ST_TW_INIT:
            begin
                cmd.op     = sdg_pkg::OP_TW_RD0;
                state_next = sdg_pkg::ST_TW_HI;
            end
            sdg_pkg::ST_TW_HI:
            begin
                cmd.op     = sdg_pkg::OP_TW_HI;
                state_next = sdg_pkg::ST_TW_RD;
            end
            sdg_pkg::ST_TW_RD:
            begin
                cmd.op     = sdg_pkg::OP_TW_RD;
                state_next = sdg_pkg::ST_TW_WR;
            end
            sdg_pkg::ST_TW_WR:
            begin
                cmd.op = sdg_pkg::OP_TW_WR;
                if (i_reg == sdg_pkg::IDX_W'(sdg_pkg::MT_N - 1))
                begin
                    pos_next   = '0;
                    state_next = sdg_pkg::ST_NEXT;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = sdg_pkg::ST_TW_RD;
                end
            end
            sdg_pkg::ST_TEMPER:
            begin
                cmd.op     = sdg_pkg::OP_DIV_START;
                state_next = sdg_pkg::ST_DIV;
            end
            sdg_pkg::ST_DIV:
            begin
                if (sts.div_done)
                    state_next = sdg_pkg::ST_SW_RD;
            end
            sdg_pkg::ST_SW_RD:
            begin
                cmd.op     = sdg_pkg::OP_SW_RD;
                state_next = sdg_pkg::ST_SW_WR;
            end
            sdg_pkg::ST_SW_WR:
            begin
                cmd.op = sdg_pkg::OP_SW_WR;
                if (k_reg == sdg_pkg::FACE_W'(sdg_pkg::FACES - 2))
                    state_next = sdg_pkg::ST_LAST_RD;
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = sdg_pkg::ST_NEXT;
                end
            end
            sdg_pkg::ST_LAST_RD:
            begin
                cmd.op     = sdg_pkg::OP_LAST_RD;
                state_next = sdg_pkg::ST_LAST_WR;
            end
            sdg_pkg::ST_LAST_WR:
            begin
                cmd.op = sdg_pkg::OP_LAST_WR;
                if (turn_reg == sdg_pkg::TURN_W'(TURNS - 1))
                begin
                    if (lvl_reg == sdg_pkg::LVL_W'(LEVELS - 1))
                    begin
                        // last row of the table: mark it built and serve the word
                        cmd.op     = sdg_pkg::OP_LAST_BUILT;
                        lvl_next   = '0;
                        state_next = sdg_pkg::ST_LK_MUL;
                    end
                    else
                    begin
                        lvl_next   = lvl_reg + 1'b1;
                        turn_next  = sdg_pkg::TURN_W'(lvl_reg) + 1'b1;
                        state_next = sdg_pkg::ST_ROW;
                    end
                end
                else
                begin
                    turn_next  = turn_reg + 1'b1;
                    state_next = sdg_pkg::ST_ROW;
                end
            end
            sdg_pkg::ST_LK_MUL:
            begin
                cmd.op     = sdg_pkg::OP_LK_MUL;
                state_next = sdg_pkg::ST_LK_RD;
            end
            sdg_pkg::ST_LK_RD:
            begin
                cmd.op     = sdg_pkg::OP_LK_RD;
                state_next = sdg_pkg::ST_LK_V;
            end
            sdg_pkg::ST_LK_V:
            begin
                cmd.op = sdg_pkg::OP_LK_V;
                if (sts.lk_last)
                    state_next = sdg_pkg::ST_DONE;
                else
                begin
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = sdg_pkg::ST_LK_MUL;
                end
            end
            sdg_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = sdg_pkg::OP_OUT;
                    state_next = sdg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sdg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sdg_dp.sv -----
// Datapath: seed register, twister memory, shuffle row buffer, permutation table,
// base-36 digit split and result register. Depends on sdg_pkg and sdg_modu.
module sdg_dp #(
    parameter int TURNS  = sdg_pkg::TURNS_DEF,
    parameter int LEVELS = sdg_pkg::LEVELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sdg_pkg::sdg_cmd_t                 cmd,
    output sdg_pkg::sdg_sts_t                 sts,
    input  logic [sdg_pkg::TRIAL_W-1:0]       trial_index,
    input  logic [sdg_pkg::TURN_IN_W-1:0]     turn_index,
    input  logic                              cfg_valid,
    input  logic [sdg_pkg::SEED_W-1:0]        cfg_seed,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic [sdg_pkg::DIE_W-1:0]         die_first,
    output logic [sdg_pkg::DIE_W-1:0]         die_second
);

    localparam int TAB_DEPTH = LEVELS * TURNS * sdg_pkg::FACES;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);
    localparam int FW        = sdg_pkg::FACE_W;

    // Configuration and build status
    logic [31:0] seed_reg;
    logic [31:0] built_seed_reg;
    logic        table_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg        <= '0;
            built_seed_reg  <= '0;
            table_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                seed_reg <= cfg_seed;
            if (cmd.op == sdg_pkg::OP_LAST_BUILT)
            begin
                built_seed_reg  <= seed_reg;
                table_valid_reg <= 1'b1;
            end
        end
    end

    // Twister memory and seeding / twist arithmetic
    logic [31:0]               mt_mem [0:sdg_pkg::MT_N-1];
    logic [31:0]               mt_a_reg, mt_b_reg;
    logic [31:0]               prev_reg, prod_reg;
    logic                      hi_reg;
    logic [sdg_pkg::IDX_W-1:0] mt_ra, mt_rb;
    logic [sdg_pkg::IDX_W:0]   idx_m;
    logic [31:0]               seed_word, tw_y, tw_word, mix;

    assign idx_m     = {1'b0, cmd.idx} + (sdg_pkg::IDX_W + 1)'(sdg_pkg::MT_M);
    assign mix       = prev_reg ^ (prev_reg >> 30);
    assign seed_word = prod_reg + 32'(cmd.idx);
    assign tw_y      = {hi_reg, mt_a_reg[30:0]};
    assign tw_word   = mt_b_reg ^ (tw_y >> 1) ^ (tw_y[0] ? sdg_pkg::MT_MATRIX : 32'd0);

    always_comb
    begin
        case (cmd.op)
            sdg_pkg::OP_TW_RD0: mt_ra = '0;
            sdg_pkg::OP_TW_RD:
                mt_ra = (cmd.idx == sdg_pkg::IDX_W'(sdg_pkg::MT_N - 1)) ? '0 : cmd.idx + 1'b1;
            default:            mt_ra = cmd.idx;
        endcase
        if (idx_m >= (sdg_pkg::IDX_W + 1)'(sdg_pkg::MT_N))
            mt_rb = sdg_pkg::IDX_W'(idx_m - (sdg_pkg::IDX_W + 1)'(sdg_pkg::MT_N));
        else
            mt_rb = idx_m[sdg_pkg::IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        mt_a_reg <= mt_mem[mt_ra];
        mt_b_reg <= mt_mem[mt_rb];
        case (cmd.op)
            sdg_pkg::OP_SEED0:
            begin
                mt_mem[0] <= seed_reg;
                prev_reg  <= seed_reg;
            end
            sdg_pkg::OP_SEED_MUL:
            begin
                prod_reg <= sdg_pkg::MT_MULT * mix;
            end
            sdg_pkg::OP_SEED_WR:
            begin
                mt_mem[cmd.idx] <= seed_word;
                prev_reg        <= seed_word;
            end
            sdg_pkg::OP_TW_HI:
            begin
                hi_reg <= mt_a_reg[31];
            end
            sdg_pkg::OP_TW_WR:
            begin
                mt_mem[cmd.idx] <= tw_word;
                hi_reg          <= mt_a_reg[31];
            end
            default:
            begin
            end
        endcase
    end

    // Draw modulo (36 - k)
    logic [FW-1:0] div_rem;
    logic          div_done;

    sdg_modu u_modu (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == sdg_pkg::OP_DIV_START),
        .dividend (sdg_pkg::temper(mt_a_reg)),
        .divisor  (FW'(sdg_pkg::FACES) - cmd.k),
        .rem      (div_rem),
        .done     (div_done)
    );

    // Shuffle row buffer; an entry not yet written reads as its own index
    logic [FW-1:0]              rb_mem [0:sdg_pkg::FACES-1];
    logic [sdg_pkg::FACES-1:0]  rb_valid_reg;
    logic [FW-1:0]              rba_reg, rbb_reg, rba_idx_reg, rbb_idx_reg;
    logic                       rba_ok_reg, rbb_ok_reg;
    logic [FW-1:0]              rb_ra, rb_kr, rb_a_val, rb_b_val;

    assign rb_kr    = cmd.k + div_rem;
    assign rb_ra    = (cmd.op == sdg_pkg::OP_LAST_RD) ? FW'(sdg_pkg::FACES - 1) : cmd.k;
    assign rb_a_val = rba_ok_reg ? rba_reg : rba_idx_reg;
    assign rb_b_val = rbb_ok_reg ? rbb_reg : rbb_idx_reg;

    always_ff @(posedge clk)
    begin
        rba_reg     <= rb_mem[rb_ra];
        rbb_reg     <= rb_mem[rb_kr];
        rba_idx_reg <= rb_ra;
        rbb_idx_reg <= rb_kr;
        rba_ok_reg  <= rb_valid_reg[rb_ra];
        rbb_ok_reg  <= rb_valid_reg[rb_kr];
        if (cmd.op == sdg_pkg::OP_SW_WR)
            rb_mem[rb_kr] <= rb_a_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rb_valid_reg <= '0;
        else if (cmd.op == sdg_pkg::OP_ROW)
            rb_valid_reg <= '0;
        else if (cmd.op == sdg_pkg::OP_SW_WR)
            rb_valid_reg[rb_kr] <= 1'b1;
    end

    // Lookup: base-36 digit of the trial, level position, table read
    logic [sdg_pkg::TRIAL_W-1:0] trial_q_reg;
    logic [sdg_pkg::TURN_W-1:0]  turn_c_reg, turn_c;
    logic [sdg_pkg::LVL_W-1:0]   top_reg, top_c;
    logic [FW-1:0]               v_reg, tab_rd_reg, lk_pos;
    logic [43:0]                 lk_prod_reg;
    logic [21:0]                 lk_x;
    logic [18:0]                 lk_qe, lk_q;
    logic [4:0]                  lk_r5;
    logic [3:0]                  lk_r9;
    logic [FW-1:0]               lk_digit;
    logic [FW:0]                 lk_sum;
    logic [21:0]                 lk_diff;

    assign lk_x     = trial_q_reg[sdg_pkg::TRIAL_W-1:2];
    assign lk_qe    = lk_prod_reg[43:sdg_pkg::RECIP_SH];
    assign lk_diff  = lk_x - 22'(lk_qe) * 22'd9;
    assign lk_r5    = lk_diff[4:0];
    assign lk_q     = (lk_r5 >= 5'd9) ? lk_qe + 1'b1 : lk_qe;
    assign lk_r9    = (lk_r5 >= 5'd9) ? 4'(lk_r5 - 5'd9) : lk_r5[3:0];
    assign lk_digit = {lk_r9, trial_q_reg[1:0]};
    assign lk_sum   = {1'b0, lk_digit} + {1'b0, v_reg};
    assign lk_pos   = (lk_sum >= (FW + 1)'(sdg_pkg::FACES)) ?
                      FW'(lk_sum - (FW + 1)'(sdg_pkg::FACES)) : lk_sum[FW-1:0];

    // Turn clamp and number of levels used
    always_comb
    begin
        if (32'(turn_index) >= TURNS)
            turn_c = sdg_pkg::TURN_W'(TURNS - 1);
        else
            turn_c = sdg_pkg::TURN_W'(turn_index);
        if (turn_c < sdg_pkg::TURN_W'(LEVELS - 1))
            top_c = turn_c[sdg_pkg::LVL_W-1:0];
        else
            top_c = sdg_pkg::LVL_W'(LEVELS - 1);
    end

    function automatic logic [TAB_AW-1:0] tab_addr(
        input logic [sdg_pkg::LVL_W-1:0]  lvl,
        input logic [sdg_pkg::TURN_W-1:0] turn,
        input logic [FW-1:0]              pos
    );
        return TAB_AW'((32'(lvl) * TURNS + 32'(turn)) * sdg_pkg::FACES + 32'(pos));
    endfunction

    // Permutation table
    logic [FW-1:0]     tab_mem [0:TAB_DEPTH-1];
    logic [TAB_AW-1:0] tab_wa;
    logic [FW-1:0]     tab_wd;
    logic              tab_we;

    always_comb
    begin
        tab_we = 1'b0;
        tab_wa = tab_addr(cmd.lvl, cmd.turn, cmd.k);
        tab_wd = rb_b_val;
        case (cmd.op)
            sdg_pkg::OP_SW_WR:
            begin
                tab_we = 1'b1;
            end
            sdg_pkg::OP_LAST_WR, sdg_pkg::OP_LAST_BUILT:
            begin
                tab_we = 1'b1;
                tab_wa = tab_addr(cmd.lvl, cmd.turn, FW'(sdg_pkg::FACES - 1));
                tab_wd = rb_a_val;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
            tab_mem[tab_wa] <= tab_wd;
        tab_rd_reg <= tab_mem[tab_addr(cmd.lvl, turn_c_reg, lk_pos)];
    end

    // Lookup registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            sdg_pkg::OP_LOAD:
            begin
                trial_q_reg <= trial_index;
                turn_c_reg  <= turn_c;
                top_reg     <= top_c;
                v_reg       <= '0;
            end
            sdg_pkg::OP_LK_MUL:
            begin
                lk_prod_reg <= 44'(lk_x) * 44'(sdg_pkg::RECIP9);
            end
            sdg_pkg::OP_LK_RD:
            begin
                trial_q_reg <= sdg_pkg::TRIAL_W'(lk_q);
            end
            sdg_pkg::OP_LK_V:
            begin
                v_reg <= tab_rd_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Result register
    logic                      rsp_valid_reg;
    logic [sdg_pkg::DIE_W-1:0] die_first_reg, die_second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.op == sdg_pkg::OP_OUT)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == sdg_pkg::OP_OUT)
        begin
            die_first_reg  <= sdg_pkg::die_hi(v_reg);
            die_second_reg <= sdg_pkg::die_lo(v_reg);
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign die_first  = die_first_reg;
    assign die_second = die_second_reg;

    // Status
    assign sts.need_rebuild = !table_valid_reg || (built_seed_reg != seed_reg);
    assign sts.div_done     = div_done;
    assign sts.lk_last      = (cmd.lvl == top_reg);
    assign sts.out_free     = !rsp_valid_reg || rsp_ready;

endmodule

// ----- rtl/stratified_dice_generator.sv -----
// Top level of the stratified dice generator: controller plus datapath.
// Depends on sdg_pkg, sdg_if, sdg_ctrl, sdg_dp and sdg_modu.
//
//   channel  dir  fields                      word
//   req      in   trial_index, turn_index     one dice request
//   rsp      out  die_first, die_second       one dice pair
//   cfg      in   seed                        generator seed
//
// A lookup steps through LK_MUL, LK_RD and LK_V once per level used, min(LEVELS-1, turn)+1
// levels, between the load in IDLE and the output in DONE, set by the dependent table reads.
// After reset or a seed change the first word first rebuilds the table, with each draw
// of the shuffle passing through the remainder unit, plus the twist passes.
// The result register lets the next word be taken while a pair waits on rsp.
// The table memory is not cleared at reset; the first word always rebuilds it.
module stratified_dice_generator #(
    parameter int TURNS  = sdg_pkg::TURNS_DEF,
    parameter int LEVELS = sdg_pkg::LEVELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    sdg_req_if.sink    req,
    sdg_rsp_if.source  rsp,
    sdg_cfg_if.sink    cfg
);

    sdg_pkg::sdg_cmd_t cmd;
    sdg_pkg::sdg_sts_t sts;

    // Seed writes are always taken
    assign cfg.ready = 1'b1;

    sdg_ctrl #(
        .TURNS  (TURNS),
        .LEVELS (LEVELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sdg_dp #(
        .TURNS  (TURNS),
        .LEVELS (LEVELS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .trial_index (req.trial_index),
        .turn_index  (req.turn_index),
        .cfg_valid   (cfg.valid),
        .cfg_seed    (cfg.seed),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .die_first   (rsp.die_first),
        .die_second  (rsp.die_second)
    );

endmodule

// ----- rtl/sdg_checker.sv -----
// Port-level checks for the stratified dice generator, bound to the top level.
// Depends on sdg_pkg for field widths.
module sdg_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [sdg_pkg::DIE_W-1:0]   die_first,
    input logic [sdg_pkg::DIE_W-1:0]   die_second
);

    // A stalled result word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its dice
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(die_first) && $stable(die_second))
        else $error("result dice changed while stalled");

    // One word at a time: request side closes after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a word is in progress");

    // Both dice are faces of a die
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (die_first >= 3'd1) && (die_first <= 3'd6) &&
                      (die_second >= 3'd1) && (die_second <= 3'd6))
        else $error("die value out of range");

endmodule

bind stratified_dice_generator sdg_checker u_sdg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .die_first  (rsp.die_first),
    .die_second (rsp.die_second)
);

// ----- bench/stratified_dice_generator_tb.sv -----
// Testbench for stratified_dice_generator: random and directed dice requests under three seeds.
// Depends on sdg_pkg, the channel interfaces in sdg_if and the RTL top level.
module stratified_dice_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PERM_TURNS  = sdg_pkg::TURNS_DEF;
    localparam int PERM_LEVELS = sdg_pkg::LEVELS_DEF;
    localparam longint CYCLE_LIMIT = 6_000_000;

    typedef struct {
        bit [sdg_pkg::DIE_W-1:0] first;
        bit [sdg_pkg::DIE_W-1:0] second;
    } dice_pair_t;

    typedef struct {
        bit [sdg_pkg::TRIAL_W-1:0]   trial;
        bit [sdg_pkg::TURN_IN_W-1:0] turn;
    } dice_req_t;

    logic clk;
    logic rst_n;

    sdg_req_if req_if ();
    sdg_rsp_if rsp_if ();
    sdg_cfg_if cfg_if ();

    stratified_dice_generator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // Predictor state: seed register, permutation table and twister
    bit [sdg_pkg::SEED_W-1:0] seed_reg;
    bit [sdg_pkg::SEED_W-1:0] seed_in_table;
    bit                       perms_built;
    bit [sdg_pkg::FACE_W-1:0] perm_mem [PERM_LEVELS][PERM_TURNS][sdg_pkg::FACES];
    bit [31:0]                mt_words [sdg_pkg::MT_N];
    int                       mt_pos;

    dice_pair_t dice_expected [$];
    bit         failed;
    bit         no_idle;
    longint     cycle_count;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Twister seeding and draws
    function automatic void twister_seed(input bit [31:0] s);
        bit [31:0] p;
        mt_words[0] = s;
        for (int i = 1; i < sdg_pkg::MT_N; i++)
        begin
            p = mt_words[i-1];
            mt_words[i] = sdg_pkg::MT_MULT * (p ^ (p >> 30)) + 32'(i);
        end
        mt_pos = sdg_pkg::MT_N;
    endfunction

    function automatic bit [31:0] twister_draw();
        bit [31:0] y;
        bit [31:0] v;
        if (mt_pos >= sdg_pkg::MT_N)
        begin
            for (int i = 0; i < sdg_pkg::MT_N; i++)
            begin
                y = (mt_words[i] & 32'h8000_0000) |
                    (mt_words[(i+1) % sdg_pkg::MT_N] & 32'h7FFF_FFFF);
                v = mt_words[(i + sdg_pkg::MT_M) % sdg_pkg::MT_N] ^ (y >> 1);
                if (y[0])
                    v ^= sdg_pkg::MT_MATRIX;
                mt_words[i] = v;
            end
            mt_pos = 0;
        end
        y = mt_words[mt_pos];
        mt_pos++;
        y ^= y >> 11;
        y ^= (y << 7) & 32'h9D2C5680;
        y ^= (y << 15) & 32'hEFC60000;
        y ^= y >> 18;
        return y;
    endfunction

    // Shuffle every used permutation from the current seed
    function automatic void build_perms();
        bit [31:0]                r;
        bit [sdg_pkg::FACE_W-1:0] t;
        twister_seed(seed_reg);
        for (int lvl = 0; lvl < PERM_LEVELS; lvl++)
        begin
            for (int tn = lvl; tn < PERM_TURNS; tn++)
            begin
                for (int k = 0; k < sdg_pkg::FACES; k++)
                    perm_mem[lvl][tn][k] = sdg_pkg::FACE_W'(k);
                for (int k = 0; k < sdg_pkg::FACES - 1; k++)
                begin
                    r = twister_draw() % (sdg_pkg::FACES - k);
                    t = perm_mem[lvl][tn][k];
                    perm_mem[lvl][tn][k] = perm_mem[lvl][tn][k + r];
                    perm_mem[lvl][tn][k + r] = t;
                end
            end
        end
        seed_in_table = seed_reg;
        perms_built = 1'b1;
    endfunction

    // Dice pair for one request; rebuilds lazily like the block
    function automatic dice_pair_t predict_dice(input dice_req_t rq);
        longint unsigned divisor;
        int              tn;
        int              top;
        int              v;
        dice_pair_t      pr;
        if (!perms_built || seed_in_table != seed_reg)
            build_perms();
        tn = (rq.turn >= PERM_TURNS) ? PERM_TURNS - 1 : int'(rq.turn);
        top = (tn < PERM_LEVELS - 1) ? tn : PERM_LEVELS - 1;
        divisor = 1;
        v = 0;
        for (int lvl = 0; lvl <= top; lvl++)
        begin
            v = perm_mem[lvl][tn][((longint'(rq.trial) / divisor) + v) % sdg_pkg::FACES];
            divisor *= sdg_pkg::FACES;
        end
        pr.first  = sdg_pkg::DIE_W'(v / 6 + 1);
        pr.second = sdg_pkg::DIE_W'(v % 6 + 1);
        return pr;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Request driver: one word per call, valid held high across back-to-back words
    task automatic send_dice_req(input dice_req_t rq);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.trial_index <= rq.trial;
        req_if.turn_index  <= rq.turn;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        dice_expected.insert(dice_expected.size(), predict_dice(rq));
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (dice_expected.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_seed(input bit [sdg_pkg::SEED_W-1:0] s);
        cfg_if.valid <= 1'b1;
        cfg_if.seed  <= s;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        seed_reg = s;
    endtask

    task automatic random_phase(input int count);
        dice_req_t rq;
        int        sel;
        for (int n = 0; n < count; n++)
        begin
            no_idle = (n >= count / 3) && (n < count / 3 + 25);
            sel = $urandom_range(0, 9);
            if (sel < 5)
                rq.trial = sdg_pkg::TRIAL_W'($urandom());
            else if (sel < 8)
                rq.trial = sdg_pkg::TRIAL_W'($urandom_range(0, 1500));
            else
                rq.trial = sdg_pkg::TRIAL_W'($urandom_range(16777215 - 50, 16777215));
            rq.turn = ($urandom_range(0, 3) == 0) ?
                      sdg_pkg::TURN_IN_W'($urandom_range(0, 7)) :
                      sdg_pkg::TURN_IN_W'($urandom());
            send_dice_req(rq);
        end
        no_idle = 1'b0;
    endtask

    // Result checker with random stalls
    initial
    begin
        dice_pair_t exp_pair;
        int         stall;
        rsp_if.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (dice_expected.size() == 0)
                begin
                    $display("%0t: unexpected dice word %0d,%0d", $time,
                             rsp_if.die_first, rsp_if.die_second);
                    failed = 1'b1;
                end
                else
                begin
                    exp_pair = dice_expected.pop_front();
                    if (rsp_if.die_first !== exp_pair.first)
                    begin
                        $display("%0t: die_first expected %0d actual %0d", $time,
                                 exp_pair.first, rsp_if.die_first);
                        failed = 1'b1;
                    end
                    if (rsp_if.die_second !== exp_pair.second)
                    begin
                        $display("%0t: die_second expected %0d actual %0d", $time,
                                 exp_pair.second, rsp_if.die_second);
                        failed = 1'b1;
                    end
                end
            end
            if (stall > 0)
                stall--;
            else
                stall = pick_gap();
            rsp_if.ready <= (rst_n && stall == 0);
        end
    end

    // Directed rows: extremes of trial and turn, level count edges, base-36 digit edges.
    // No pair can be read off by eye here, so every row goes through the predictor.
    dice_req_t directed_rows [] = '{
        '{24'd0,        7'd0},   '{24'hFFFFFF, 7'd0},   '{24'd35,       7'd0},
        '{24'd36,       7'd1},   '{24'd0,      7'd1},   '{24'd1295,     7'd2},
        '{24'd1296,     7'd2},   '{24'd46655,  7'd3},   '{24'd46656,    7'd3},
        '{24'd1679615,  7'd4},   '{24'd1679616,7'd4},   '{24'hFFFFFF,   7'd5},
        '{24'd0,        7'd5},   '{24'd0,      7'd6},   '{24'hFFFFFF,   7'd6},
        '{24'd0,        7'd127}, '{24'hFFFFFF, 7'd127}, '{24'hAAAAAA,   7'd85},
        '{24'h555555,   7'd42},  '{24'd12345,  7'd126}
    };

    // Main sequence
    initial
    begin
        failed        = 1'b0;
        no_idle       = 1'b0;
        seed_reg      = '0;
        seed_in_table = '0;
        perms_built   = 1'b0;
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.trial_index = '0;
        req_if.turn_index  = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.seed        = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset seed: directed rows then random words
        foreach (directed_rows[i])
            send_dice_req(directed_rows[i]);
        random_phase(110);
        drain_results();

        // All-ones seed
        write_seed(32'hFFFF_FFFF);
        random_phase(135);
        drain_results();

        // Random seed
        write_seed($urandom());
        random_phase(135);
        drain_results();

        if (!failed)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
